// ===== rtl/pbr_pkg.sv =====
// ----------------------------------------------------------------------------
// pbr_pkg
// shared types, codes and instruction encodings of the branch relocator
// ----------------------------------------------------------------------------
`default_nettype none

package pbr_pkg;

	// kind of sequence a request turns into
	localparam logic [1:0] MODE_PASS  = 2'd0;
	localparam logic [1:0] MODE_JUMP4 = 2'd1;
	localparam logic [1:0] MODE_JUMP6 = 2'd2;

	// primary opcodes and branch fields
	localparam logic [5:0] OPC_BC    = 6'd16;
	localparam logic [5:0] OPC_B     = 6'd18;
	localparam logic [4:0] BO_ALWAYS = 5'd20;

	// fixed instruction words
	localparam logic [31:0] INS_STD_R0   = 32'hF801FFD0;
	localparam logic [31:0] INS_LD_R0    = 32'hE801FFD0;
	localparam logic [31:0] INS_LIS_R0   = 32'h3C000000;
	localparam logic [31:0] INS_ORI_R0   = 32'h60000000;
	localparam logic [31:0] INS_MTCTR_R0 = 32'h7C0903A6;
	localparam logic [31:0] INS_BCCTR    = 32'h4C000420;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// classified request: for a pass-through the word sits in target
	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] target;
		logic [4:0]  bo;
		logic [4:0]  bi;
		logic        lk;
	} desc_t;

endpackage

`default_nettype wire

// ===== rtl/pbr_front.sv =====
// ----------------------------------------------------------------------------
// pbr_front
// accepts requests, classifies them and works out the branch target
// ----------------------------------------------------------------------------
`default_nettype none

module pbr_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire logic           op,
	input  wire logic [31:0]    instr_word,
	input  wire logic [31:0]    instr_addr,
	input  wire logic [31:0]    jump_target,
	input  wire logic           link,
	input  wire logic           preserve,
	output logic                push_valid,
	input  wire logic           push_ready,
	output pbr_pkg::desc_t      push_desc
);

	pbr_pkg::desc_t desc;
	pbr_pkg::desc_t desc_s1;
	logic           valid_s1;
	logic           accept;
	logic [5:0]     opc;
	logic           is_b;
	logic           is_bc;
	logic [31:0]    disp;

	assign opc   = instr_word[31:26];
	assign is_b  = (opc == pbr_pkg::OPC_B);
	assign is_bc = (opc == pbr_pkg::OPC_BC);

	// sign-extended displacement, 26 bits for b and 16 bits for bc
	assign disp = is_b ? {{6{instr_word[25]}}, instr_word[25:2], 2'b00}
	                   : {{16{instr_word[15]}}, instr_word[15:2], 2'b00};

	always_comb begin
		desc = '0;
		if (op) begin
			desc.mode   = preserve ? pbr_pkg::MODE_JUMP6 : pbr_pkg::MODE_JUMP4;
			desc.target = jump_target;
			desc.bo     = pbr_pkg::BO_ALWAYS;
			desc.bi     = 5'd0;
			desc.lk     = link;
		end else if ((!is_b && !is_bc) || instr_word[1]) begin
			desc.mode   = pbr_pkg::MODE_PASS;
			desc.target = instr_word;
		end else begin
			desc.mode   = pbr_pkg::MODE_JUMP6;
			desc.target = instr_addr + disp;
			desc.bo     = is_b ? pbr_pkg::BO_ALWAYS : instr_word[25:21];
			desc.bi     = is_b ? 5'd0 : instr_word[20:16];
			desc.lk     = instr_word[0];
		end
	end

	assign req_stall = valid_s1 && !push_ready;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !push_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc;
		end
	end

	assign push_valid = valid_s1;
	assign push_desc  = desc_s1;

endmodule

`default_nettype wire

// ===== rtl/pbr_queue.sv =====
// ----------------------------------------------------------------------------
// pbr_queue
// short queue of classified requests between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module pbr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire pbr_pkg::desc_t push_desc,
	output logic                pop_valid,
	input  wire logic           pop,
	output pbr_pkg::desc_t      pop_desc
);

	pbr_pkg::desc_t                  entry_q [pbr_pkg::QUEUE_DEPTH];
	logic [pbr_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [pbr_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [pbr_pkg::QUEUE_CW-1:0]    count_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = (count_q != pbr_pkg::QUEUE_CW'(pbr_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_desc   = entry_q[rd_ptr_q];

	function automatic logic [pbr_pkg::QUEUE_AW-1:0] next_ptr(
		input logic [pbr_pkg::QUEUE_AW-1:0] ptr
	);
		if (ptr == pbr_pkg::QUEUE_AW'(pbr_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pbr_back.sv =====
// ----------------------------------------------------------------------------
// pbr_back
// steps through a classified request and emits its words one per cycle while the result side does not stall
// ----------------------------------------------------------------------------
`default_nettype none

module pbr_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	output logic                q_pop,
	input  wire pbr_pkg::desc_t q_desc,
	output logic                res_valid,
	input  wire logic           res_stall,
	output logic [31:0]         word,
	output logic                last
);

	pbr_pkg::desc_t cur_q;
	logic           cur_valid_q;
	logic [2:0]     step_q;
	logic           res_valid_q;
	logic [31:0]    word_q;
	logic           last_q;
	logic           adv;
	logic           cur_last;
	logic [31:0]    next_word;
	logic [31:0]    w_lis;
	logic [31:0]    w_ori;
	logic [31:0]    w_bcctr;

	assign w_lis   = pbr_pkg::INS_LIS_R0 | {16'd0, cur_q.target[31:16]};
	assign w_ori   = pbr_pkg::INS_ORI_R0 | {16'd0, cur_q.target[15:0]};
	assign w_bcctr = pbr_pkg::INS_BCCTR | {6'd0, cur_q.bo, cur_q.bi, 15'd0, cur_q.lk};

	always_comb begin
		next_word = cur_q.target;
		cur_last  = 1'b1;
		case (cur_q.mode)
			pbr_pkg::MODE_JUMP4: begin
				cur_last = (step_q == 3'd3);
				case (step_q)
					3'd0:    next_word = w_lis;
					3'd1:    next_word = w_ori;
					3'd2:    next_word = pbr_pkg::INS_MTCTR_R0;
					default: next_word = w_bcctr;
				endcase
			end
			pbr_pkg::MODE_JUMP6: begin
				cur_last = (step_q == 3'd5);
				case (step_q)
					3'd0:    next_word = pbr_pkg::INS_STD_R0;
					3'd1:    next_word = w_lis;
					3'd2:    next_word = w_ori;
					3'd3:    next_word = pbr_pkg::INS_MTCTR_R0;
					3'd4:    next_word = pbr_pkg::INS_LD_R0;
					default: next_word = w_bcctr;
				endcase
			end
			default: begin
				next_word = cur_q.target;
				cur_last  = 1'b1;
			end
		endcase
	end

	// output register frees whenever it is empty or being taken
	assign adv   = !res_valid_q || !res_stall;
	assign q_pop = q_valid && (!cur_valid_q || (adv && cur_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= 3'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				res_valid_q <= cur_valid_q;
				if (cur_valid_q) begin
					step_q <= cur_last ? 3'd0 : step_q + 3'd1;
				end
			end
			if (q_pop) begin
				cur_valid_q <= 1'b1;
			end else if (adv && cur_last) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_desc;
		end
		if (adv && cur_valid_q) begin
			word_q <= next_word;
			last_q <= cur_last;
		end
	end

	assign res_valid = res_valid_q;
	assign word      = word_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ===== rtl/powerpc_branch_relocator.sv =====
// ----------------------------------------------------------------------------
// powerpc_branch_relocator
// relocates powerpc branches and builds far jumps through ctr
// ----------------------------------------------------------------------------
// Each request either relocates one instruction word (op 0) or builds a far
// jump to jump_target (op 1), and the block answers with a run of instruction
// words on word, with last marking the final word of the run. A word that is
// not a relative b or bc comes back unchanged as a single word; a relative b
// or bc becomes the six-word save/lis/ori/mtctr/restore/bcctr sequence to its
// target; a far jump is four words, or six with preserve. The result port
// moves one word per cycle while res_stall is low, and that port alone sets
// the sustained rate. Requests are taken on consecutive cycles until the
// queue fills: a front register classifies each request and works out its
// target, a two-entry queue holds the classified requests and a back
// sequencer with its own output register emits the words, so requests still
// enter while a word waits on res_stall. A request passes the front register,
// a queue entry, the current-request register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module powerpc_branch_relocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        op,
	input  wire logic [31:0] instr_word,
	input  wire logic [31:0] instr_addr,
	input  wire logic [31:0] jump_target,
	input  wire logic        link,
	input  wire logic        preserve,
	// result channel
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [31:0]      word,
	output logic             last
);

	// front to queue
	logic           push_valid;
	logic           push_ready;
	pbr_pkg::desc_t push_desc;

	// queue to back
	logic           q_valid;
	logic           q_pop;
	pbr_pkg::desc_t q_desc;

	// classification and target add, one register stage
	pbr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.op          (op),
		.instr_word  (instr_word),
		.instr_addr  (instr_addr),
		.jump_target (jump_target),
		.link        (link),
		.preserve    (preserve),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_desc   (push_desc)
	);

	// decouples the front from the word sequencer
	pbr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_desc   (q_desc)
	);

	// word sequencer with registered output
	pbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_desc    (q_desc),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.word      (word),
		.last      (last)
	);

endmodule

`default_nettype wire

// ===== rtl/pbr_checker.sv =====
// ----------------------------------------------------------------------------
// pbr_checker
// port-level checks of the branch relocator
// ----------------------------------------------------------------------------
`default_nettype none

module pbr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_stall,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire logic [31:0] word,
	input wire logic        last
);

	logic       req_acc;
	logic       res_acc;
	logic [3:0] open_q;
	logic [2:0] run_q;

	assign req_acc = req_valid && !req_stall;
	assign res_acc = res_valid && !res_stall;

	// requests taken whose final word has not gone yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 4'd0;
		end else if (req_acc && !(res_acc && last)) begin
			open_q <= open_q + 4'd1;
		end else if (!req_acc && res_acc && last) begin
			open_q <= open_q - 4'd1;
		end
	end

	// words delivered so far in the current run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 3'd0;
		end else if (res_acc) begin
			run_q <= last ? 3'd0 : run_q + 3'd1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result valid dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(word) && $stable(last))
		else $error("stalled result changed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> open_q != 4'd0)
		else $error("result word with no open request");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && run_q == 3'd5 |-> last)
		else $error("run longer than six words");

endmodule

bind powerpc_branch_relocator pbr_checker u_pbr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.word      (word),
	.last      (last)
);

`default_nettype wire

// ===== dv/pbr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbr_scoreboard
// watches both channels of the branch relocator and checks every word it emits
// ----------------------------------------------------------------------------
// Each accepted request is turned into the words it should produce. Those
// words are queued in order and compared with the accepted result words.
// ----------------------------------------------------------------------------

module pbr_scoreboard (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	input  wire logic        req_stall,
	input  wire logic        far_jump,
	input  wire logic [31:0] instr_word,
	input  wire logic [31:0] instr_addr,
	input  wire logic [31:0] jump_target,
	input  wire logic        link,
	input  wire logic        preserve,
	input  wire logic        res_valid,
	input  wire logic        res_stall,
	input  wire logic [31:0] word,
	input  wire logic        last,
	output int               error_count,
	output int               words_outstanding
);

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} emitted_t;

	emitted_t expected_words[$];

	function automatic void push_word(input logic [31:0] w, input logic fin);
		emitted_t e;
		e.word = w;
		e.last = fin;
		expected_words.push_back(e);
	endfunction

	// load-ctr-and-branch sequence, optionally wrapped in a save and restore of r0
	function automatic void queue_far_jump(input logic [31:0] target, input logic [4:0] bo,
			input logic [4:0] bi, input logic lk, input logic keep_r0);
		if (keep_r0)
			push_word(pbr_pkg::INS_STD_R0, 1'b0);
		push_word(pbr_pkg::INS_LIS_R0 | {16'h0000, target[31:16]}, 1'b0);
		push_word(pbr_pkg::INS_ORI_R0 | {16'h0000, target[15:0]}, 1'b0);
		push_word(pbr_pkg::INS_MTCTR_R0, 1'b0);
		if (keep_r0)
			push_word(pbr_pkg::INS_LD_R0, 1'b0);
		push_word(pbr_pkg::INS_BCCTR | {6'b000000, bo, bi, 15'h0000, lk}, 1'b1);
	endfunction

	function automatic void predict_words(input logic jump, input logic [31:0] w,
			input logic [31:0] addr, input logic [31:0] target, input logic lnk,
			input logic keep_r0);
		logic [5:0]  opcode;
		logic [31:0] disp;
		opcode = w[31:26];
		if (jump) begin
			queue_far_jump(target, pbr_pkg::BO_ALWAYS, 5'd0, lnk, keep_r0);
		end else if ((opcode != pbr_pkg::OPC_B && opcode != pbr_pkg::OPC_BC) || w[1]) begin
			push_word(w, 1'b1);
		end else if (opcode == pbr_pkg::OPC_B) begin
			disp = {{6{w[25]}}, w[25:2], 2'b00};
			queue_far_jump(addr + disp, pbr_pkg::BO_ALWAYS, 5'd0, w[0], 1'b1);
		end else begin
			disp = {{16{w[15]}}, w[15:2], 2'b00};
			queue_far_jump(addr + disp, w[25:21], w[20:16], w[0], 1'b1);
		end
	endfunction

	// results are taken before the request of the same edge: no word can
	// leave in the cycle its request enters
	always @(posedge clk) begin : watch
		emitted_t e;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, got %08h last %0b",
						$time, word, last);
					error_count++;
				end else begin
					e = expected_words.pop_front();
					if (word !== e.word) begin
						$display("%0t: word mismatch, expected %08h, got %08h",
							$time, e.word, word);
						error_count++;
					end
					if (last !== e.last) begin
						$display("%0t: last mismatch on word %08h, expected %0b, got %0b",
							$time, e.word, e.last, last);
						error_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				predict_words(far_jump, instr_word, instr_addr, jump_target, link, preserve);
			words_outstanding = expected_words.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// request stimulus and verdict for the powerpc branch relocator
// ----------------------------------------------------------------------------
// A directed set of requests covers the branch forms, the displacement
// extremes, address wrap-around and both far jump lengths; then several
// hundred random requests follow in bursts while the result side stalls in
// changing patterns. A separate checker predicts and compares every word.
// ----------------------------------------------------------------------------

module tb;

	localparam logic OP_RELOCATE = 1'b0;
	localparam logic OP_FAR_JUMP = 1'b1;

	localparam int N_RANDOM    = 420;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 20;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        req_valid   = 1'b0;
	logic        req_stall;
	logic        op          = OP_RELOCATE;
	logic [31:0] instr_word  = '0;
	logic [31:0] instr_addr  = '0;
	logic [31:0] jump_target = '0;
	logic        link        = 1'b0;
	logic        preserve    = 1'b0;
	logic        res_valid;
	logic        res_stall   = 1'b0;
	logic [31:0] word;
	logic        last;

	int error_count;
	int words_outstanding;
	int cycle_count = 0;

	// receiver stall pattern state
	int stall_style     = 0;
	int stall_phase_cnt = 0;
	int stall_run       = 0;

	always #5 clk = ~clk;

	powerpc_branch_relocator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.op          (op),
		.instr_word  (instr_word),
		.instr_addr  (instr_addr),
		.jump_target (jump_target),
		.link        (link),
		.preserve    (preserve),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.word        (word),
		.last        (last)
	);

	// op is a single bit whose high value selects the far jump
	pbr_scoreboard u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_valid         (req_valid),
		.req_stall         (req_stall),
		.far_jump          (op == OP_FAR_JUMP),
		.instr_word        (instr_word),
		.instr_addr        (instr_addr),
		.jump_target       (jump_target),
		.link              (link),
		.preserve          (preserve),
		.res_valid         (res_valid),
		.res_stall         (res_stall),
		.word              (word),
		.last              (last),
		.error_count       (error_count),
		.words_outstanding (words_outstanding)
	);

	// safety net: a hung block or a lost word ends here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: the style changes at random, so long stall
	// runs, scattered stalls and free-running stretches all meet every phase
	// of a word sequence
	always @(negedge clk) begin
		if (stall_phase_cnt == 0) begin
			stall_style     = $urandom_range(0, 3);
			stall_phase_cnt = $urandom_range(20, 80);
		end
		stall_phase_cnt--;
		case (stall_style)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			2: res_stall <= ($urandom_range(0, 9) < 6);
			default: begin
				if (stall_run == 0 && $urandom_range(0, 5) == 0)
					stall_run = $urandom_range(1, 8);
				res_stall <= (stall_run != 0);
				if (stall_run != 0)
					stall_run--;
			end
		endcase
	end

	// present one request and hold it until taken; valid stays high so that
	// a following request goes out back to back
	task automatic send_request(input logic rop, input logic [31:0] w, input logic [31:0] a,
			input logic [31:0] t, input logic lk, input logic pr);
		@(negedge clk);
		req_valid   <= 1'b1;
		op          <= rop;
		instr_word  <= w;
		instr_addr  <= a;
		jump_target <= t;
		link        <= lk;
		preserve    <= pr;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// gap in the request stream, with junk on the idle payload
	task automatic hold_off(input int n);
		repeat (n) begin
			@(negedge clk);
			req_valid   <= 1'b0;
			op          <= 1'($urandom_range(0, 1));
			instr_word  <= $urandom();
			instr_addr  <= $urandom();
			jump_target <= $urandom();
			link        <= 1'($urandom_range(0, 1));
			preserve    <= 1'($urandom_range(0, 1));
		end
	endtask

	// stop sending until every outstanding word has come back
	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (words_outstanding != 0)
			@(negedge clk);
	endtask

	// mostly relative branches with random content, since among relocated words only those
	// reach the six-word path; the rest are absolute branches, neighbouring
	// opcodes and arbitrary words
	function automatic logic [31:0] random_instr();
		logic [31:0] r;
		int          kind;
		r    = $urandom();
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2: return {pbr_pkg::OPC_B, r[25:2], 1'b0, r[0]};
			3, 4, 5: return {pbr_pkg::OPC_BC, r[25:2], 1'b0, r[0]};
			6:       return {($urandom_range(0, 1) ? pbr_pkg::OPC_B : pbr_pkg::OPC_BC),
					r[25:2], 1'b1, r[0]};
			7:       return {6'(pbr_pkg::OPC_BC + $urandom_range(0, 3)), r[25:0]};
			default: return r;
		endcase
	endfunction

	initial begin : stimulus
		int   i;
		int   burst_left;
		logic rop;

		// reset once, held low from time zero
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed requests, back to back ---
		// plain words pass straight through
		send_request(OP_RELOCATE, 32'h00000000, 32'h00000000, $urandom(), 1'b1, 1'b1);
		send_request(OP_RELOCATE, 32'hFFFFFFFF, 32'hFFFFFFFF, $urandom(), 1'b0, 1'b0);
		// opcodes either side of b, the lower one just above bc
		send_request(OP_RELOCATE, 32'h44000002, $urandom(), $urandom(), 1'b1, 1'b0);
		send_request(OP_RELOCATE, 32'h4C000020, $urandom(), $urandom(), 1'b0, 1'b1);
		// relative b: largest forward reach, target wraps past the top
		send_request(OP_RELOCATE, 32'h49FFFFFC, 32'hFFFFFFF0, $urandom(), 1'b1, 1'b0);
		// relative b: largest backward reach with link, target wraps below zero
		send_request(OP_RELOCATE, 32'h4A000001, 32'h00000010, $urandom(), 1'b0, 1'b0);
		// relative bl by minus four
		send_request(OP_RELOCATE, 32'h4BFFFFFD, 32'h80000000, $urandom(), 1'b0, 1'b1);
		// absolute b and bla stay as they are
		send_request(OP_RELOCATE, 32'h48000002, $urandom(), $urandom(), 1'b1, 1'b1);
		send_request(OP_RELOCATE, 32'h4BFFFFFF, $urandom(), $urandom(), 1'b0, 1'b0);
		// relative bc: all-ones bo and bi, largest forward reach, link
		send_request(OP_RELOCATE, 32'h43FF7FFD, 32'hFFFF8000, $urandom(), 1'b0, 1'b0);
		// relative bc: zero bo and bi, largest backward reach
		send_request(OP_RELOCATE, 32'h40008000, 32'h00000000, $urandom(), 1'b1, 1'b1);
		// absolute bc stays as it is
		send_request(OP_RELOCATE, 32'h43FFFFFE, $urandom(), $urandom(), 1'b0, 1'b1);
		// far jumps: both lengths, both link values, target extremes
		send_request(OP_FAR_JUMP, $urandom(), $urandom(), 32'h00000000, 1'b0, 1'b0);
		send_request(OP_FAR_JUMP, $urandom(), $urandom(), 32'hFFFFFFFF, 1'b1, 1'b1);
		send_request(OP_FAR_JUMP, 32'h48000000, $urandom(), 32'h12345678, 1'b1, 1'b0);
		send_request(OP_FAR_JUMP, 32'h40000000, $urandom(), 32'h8000FFFF, 1'b0, 1'b1);
		drain_results();

		// --- random requests in bursts ---
		burst_left = 0;
		for (i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2)
				drain_results();
			if (burst_left == 0) begin
				// now and then a long stretch with no gaps at all
				if ($urandom_range(0, 3) == 0) begin
					burst_left = $urandom_range(20, 60);
				end else begin
					hold_off($urandom_range(1, 7));
					burst_left = $urandom_range(1, 10);
				end
			end
			rop = ($urandom_range(0, 99) < 35) ? OP_FAR_JUMP : OP_RELOCATE;
			send_request(rop, random_instr(), $urandom(), $urandom(),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			burst_left--;
		end

		// let everything out, then watch a little longer for stray words
		drain_results();
		repeat (SETTLE) @(negedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/pbr_pkg.sv
rtl/pbr_front.sv
rtl/pbr_queue.sv
rtl/pbr_back.sv
rtl/powerpc_branch_relocator.sv
rtl/pbr_checker.sv
dv/pbr_checker.sv
dv/tb.sv
